>>> rtl/assert_macros.svh
// Assertion helpers used by the BLAKE2s controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/b2s_pkg.sv
// ----------------------------------------------------------------------------
// BLAKE2s package
// Shared types, constants and permutation table of the BLAKE2s engine.
// ----------------------------------------------------------------------------
package b2s_pkg;

	typedef logic [31:0] word_t;

	localparam logic [2:0] REG_DIGEST_LEN = 3'd0;
	localparam logic [2:0] REG_KEY_LEN    = 3'd1;
	localparam logic [2:0] REG_KEY0       = 3'd2;
	localparam logic [2:0] REG_KEY1       = 3'd3;
	localparam logic [2:0] REG_KEY2       = 3'd4;
	localparam logic [2:0] REG_KEY3       = 3'd5;

	localparam word_t PARAM_BASE = 32'h0101_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // load chain value with IV and parameter word
		logic load_key;  // place the key block in the buffer
		logic write_word; // store the input word at the fill position
		logic pad;       // zero the buffer above the fill
		logic init_v;    // load the work vector, advance the counter
		logic final_blk; // final flag for init_v
		logic g_step;    // run one quarter-round
		logic finish;    // fold the work vector into the chain value
		logic clr_fill;  // clear the fill count
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic buf_full;
		logic last_g;
	} status_t;

	function automatic word_t iv(input logic [2:0] i);
		unique case (i)
			3'd0: iv = 32'h6A09E667;
			3'd1: iv = 32'hBB67AE85;
			3'd2: iv = 32'h3C6EF372;
			3'd3: iv = 32'hA54FF53A;
			3'd4: iv = 32'h510E527F;
			3'd5: iv = 32'h9B05688C;
			3'd6: iv = 32'h1F83D9AB;
			default: iv = 32'h5BE0CD19;
		endcase
	endfunction

	// Message schedule sigma, 160 entries of four bits, row 0 in the lowest
	// 64 bits and entry 0 of each row in its lowest nibble.
	localparam logic [639:0] SIGMA = {
		64'h0CD3E9BF5167482A, 64'h5A417D2C803B9EF6, 64'hA2684F05931CE7BD,
		64'hB8293670A4DEF15C, 64'h91EF57D438B0A6C2, 64'hD386CB1EFA427509,
		64'h8F04A562EBCD1397, 64'h491763EADF250C8B, 64'h357B20C16DF984AE,
		64'hFEDCBA9876543210};

	function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
		logic [7:0] idx;
		idx = 8'(r) * 8'd16 + 8'(k);
		sigma = SIGMA[idx*4 +: 4];
	endfunction

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t bmask(input logic [2:0] n);
		unique case (n)
			3'd0: bmask = 32'h0000_0000;
			3'd1: bmask = 32'h0000_00FF;
			3'd2: bmask = 32'h0000_FFFF;
			3'd3: bmask = 32'h00FF_FFFF;
			default: bmask = 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

>>> rtl/b2s_ctrl.sv
// ----------------------------------------------------------------------------
// BLAKE2s controller
// Sequences message start, buffering, compression and digest output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module b2s_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_last,
	input  logic [2:0]        in_nb,
	input  logic              key_on,
	input  logic              out_fire,
	input  logic              out_end,
	input  b2s_pkg::status_t  sts,
	output b2s_pkg::cmd_t     cmd,
	output logic              in_ready,
	output logic              out_valid
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MID   = 3'd1;
	localparam logic [2:0] ST_CINIT = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic       in_msg_q;
	logic       last_q;
	logic       pend_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.start     = in_fire && !in_msg_q;
		cmd.load_key  = in_fire && !in_msg_q && key_on;
		cmd.write_word = ((state_q == ST_MID) && pend_q && !sts.buf_full)
			|| ((state_q == ST_FIN) && pend_q);
		cmd.pad       = (state_q == ST_MID) && last_q && !pend_q;
		cmd.init_v    = (state_q == ST_CINIT);
		cmd.final_blk = last_q && !pend_q;
		cmd.g_step    = (state_q == ST_ROUND);
		cmd.finish    = (state_q == ST_FIN);
		cmd.clr_fill  = (state_q == ST_FIN);
	end

	// State sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			in_msg_q <= 1'b0;
			last_q   <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					in_msg_q <= !in_last;
					last_q   <= in_last;
					pend_q   <= (in_nb != 3'd0);
					state_q  <= ST_MID;
				end
				// A full buffer is compressed before the pending word goes in.
				// After the last word is stored, one more pass pads the block.
				ST_MID: begin
					if (pend_q && sts.buf_full) begin
						state_q <= ST_CINIT;
					end else if (pend_q) begin
						pend_q  <= 1'b0;
						state_q <= last_q ? ST_MID : ST_IDLE;
					end else begin
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: state_q <= ST_ROUND;
				ST_ROUND: if (sts.last_g) state_q <= ST_FIN;
				ST_FIN: begin
					if (pend_q) begin
						pend_q  <= 1'b0;
						state_q <= last_q ? ST_MID : ST_IDLE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (out_fire && out_end) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_out_idle, clk, arst_n, out_valid, !in_ready, "output while accepting")
	`ASSERT_NEXT(a_round_fin, clk, arst_n, (state_q == ST_ROUND) && sts.last_g,
		state_q == ST_FIN, "round end not followed by fold")
	`ASSERT_IMPL(a_start_idle, clk, arst_n, cmd.start, state_q == ST_IDLE, "start outside idle")

endmodule

>>> rtl/b2s_datapath.sv
// ----------------------------------------------------------------------------
// BLAKE2s datapath
// Block buffer, chain value, counter, work vector and one shared G unit.
// ----------------------------------------------------------------------------
module b2s_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  b2s_pkg::cmd_t     cmd,
	input  logic [31:0]       in_word,
	input  logic [2:0]        in_nb,
	input  logic              in_fire,
	input  logic [5:0]        dlen,
	input  logic [5:0]        klen,
	input  logic [255:0]      key,
	input  logic              out_fire,
	output b2s_pkg::status_t  sts,
	output logic [31:0]       out_word,
	output logic [2:0]        out_nb,
	output logic              out_end
);

	b2s_pkg::word_t buf_q [16];
	b2s_pkg::word_t h_q [8];
	b2s_pkg::word_t v_q [16];
	logic [63:0]    cnt_q;
	logic [6:0]     fill_q;
	logic [31:0]    hold_w_q;
	logic [2:0]     hold_n_q;
	logic [3:0]     rnd_q;
	logic [2:0]     g_q;
	logic [2:0]     ok_q;

	logic [5:0] ol, kl;
	assign ol = (dlen == 6'd0) ? 6'd1 : (dlen > 6'd32) ? 6'd32 : dlen;
	assign kl = (klen > 6'd32) ? 6'd32 : klen;

	assign sts.buf_full = fill_q[6];
	assign sts.last_g   = (rnd_q == 4'd9) && (g_q == 3'd7);

	// Quarter-round operand selection.
	logic [3:0] ia, ib, ic, id;
	always_comb begin
		unique case (g_q)
			3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
			3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
			3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
			3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
			3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
			3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
			3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
			default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
		endcase
	end

	b2s_pkg::word_t mx, my, a1, d1, c1, b1, a2, d2, c2, b2;
	always_comb begin
		mx = buf_q[b2s_pkg::sigma(rnd_q, {g_q, 1'b0})];
		my = buf_q[b2s_pkg::sigma(rnd_q, {g_q, 1'b1})];
		a1 = v_q[ia] + v_q[ib] + mx;
		d1 = b2s_pkg::ror(v_q[id] ^ a1, 16);
		c1 = v_q[ic] + d1;
		b1 = b2s_pkg::ror(v_q[ib] ^ c1, 12);
		a2 = a1 + b1 + my;
		d2 = b2s_pkg::ror(d1 ^ a2, 8);
		c2 = c1 + d2;
		b2 = b2s_pkg::ror(b1 ^ c2, 7);
	end

	logic [63:0] cnt_next;
	assign cnt_next = cnt_q + (cmd.final_blk ? 64'(fill_q) : 64'd64);

	// Buffer, chain and work vector update.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 1; i < 8; i++) h_q[i] <= b2s_pkg::iv(3'(i));
			h_q[0] <= b2s_pkg::iv(3'd0) ^ b2s_pkg::PARAM_BASE ^ {18'd0, kl, 2'd0, ol};
		end
		if (in_fire) begin
			hold_w_q <= in_word;
			hold_n_q <= in_nb;
		end
		if (cmd.load_key) begin
			for (int i = 0; i < 16; i++) begin
				if (i < 8) begin
					buf_q[i] <= (6'(4*i) >= kl) ? 32'd0 :
						key[32*i +: 32] & b2s_pkg::bmask(3'((kl - 6'(4*i)) > 6'd4 ? 6'd4
						: kl - 6'(4*i)));
				end else begin
					buf_q[i] <= 32'd0;
				end
			end
		end
		if (cmd.write_word) begin
			buf_q[fill_q[5:2]] <= hold_w_q & b2s_pkg::bmask(hold_n_q);
		end
		if (cmd.pad) begin
			for (int i = 0; i < 16; i++)
				if (7'(4*i) >= fill_q + 7'd3 - ((fill_q + 7'd3) & 7'd3) && !(fill_q == 7'd64)
					&& 7'(4*i) >= fill_q)
					buf_q[i] <= 32'd0;
		end
		if (cmd.init_v) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 4; i++) v_q[i+8] <= b2s_pkg::iv(3'(i));
			v_q[12] <= b2s_pkg::iv(3'd4) ^ cnt_next[31:0];
			v_q[13] <= b2s_pkg::iv(3'd5) ^ cnt_next[63:32];
			v_q[14] <= b2s_pkg::iv(3'd6) ^ {32{cmd.final_blk}};
			v_q[15] <= b2s_pkg::iv(3'd7);
		end
		if (cmd.g_step) begin
			v_q[ia] <= a2; v_q[ib] <= b2; v_q[ic] <= c2; v_q[id] <= d2;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
		end
	end

	// Counter, fill, round counters and output index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= '0;
			rnd_q  <= '0;
			g_q    <= '0;
			ok_q   <= '0;
		end else begin
			if (cmd.start) begin
				cnt_q  <= '0;
				fill_q <= (kl != 6'd0) ? 7'd64 : 7'd0;
				ok_q   <= '0;
			end
			if (cmd.init_v) begin
				cnt_q <= cnt_next;
				rnd_q <= '0;
				g_q   <= '0;
			end
			if (cmd.g_step) begin
				g_q <= g_q + 3'd1;
				if (g_q == 3'd7) rnd_q <= rnd_q + 4'd1;
			end
			if (cmd.write_word) begin
				fill_q <= (cmd.clr_fill ? 7'd0 : fill_q) + 7'(hold_n_q);
			end else if (cmd.clr_fill) begin
				fill_q <= 7'd0;
			end
			if (out_fire) ok_q <= out_end ? 3'd0 : ok_q + 3'd1;
		end
	end

	// Digest word selection.
	logic [5:0] rem;
	assign rem      = ol - {1'b0, ok_q, 2'b00};
	assign out_nb   = (rem > 6'd4) ? 3'd4 : rem[2:0];
	assign out_end  = (rem <= 6'd4);
	assign out_word = h_q[ok_q] & b2s_pkg::bmask(out_nb);

endmodule

>>> rtl/blake2s_hash_engine.sv
// A word that fills no block is stored in the mid state, then input is open again.
// A word that finds the block full is stored in the fold, after setup and 80 quarter-rounds.
// No new word is accepted until the last one is stored, so input is bound by the shared G unit.
// After the last word the final compression runs, then up to eight digest beats follow.
// Reset (arst_n low) clears control state and counters; config registers return to defaults.
// ----------------------------------------------------------------------------
// BLAKE2s hash engine
// Plain or keyed BLAKE2s over a stream of little-endian 32-bit words.
// ----------------------------------------------------------------------------
module blake2s_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // message_word[31:0], valid_bytes[34:32], zero pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word[31:0], digest_valid_bytes[34:32], zero pad
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [5:0]   dlen_q, klen_q;
	logic [255:0] key_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q <= 6'd32;
			klen_q <= 6'd0;
			key_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				b2s_pkg::REG_DIGEST_LEN: dlen_q <= cfg_data[5:0];
				b2s_pkg::REG_KEY_LEN:    klen_q <= cfg_data[5:0];
				b2s_pkg::REG_KEY0:       key_q[63:0]    <= cfg_data;
				b2s_pkg::REG_KEY1:       key_q[127:64]  <= cfg_data;
				b2s_pkg::REG_KEY2:       key_q[191:128] <= cfg_data;
				b2s_pkg::REG_KEY3:       key_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic       in_fire, out_fire, out_end;
	logic [2:0] nb, out_nb;
	logic [31:0] out_word;
	b2s_pkg::cmd_t    cmd;
	b2s_pkg::status_t sts;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign nb = !s_tlast ? 3'd4 : (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

	b2s_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast), .in_nb(nb),
		.key_on(klen_q != 6'd0), .out_fire(out_fire), .out_end(out_end), .sts(sts),
		.cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
	);

	b2s_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(s_tdata[31:0]), .in_nb(nb),
		.in_fire(in_fire), .dlen(dlen_q), .klen(klen_q), .key(key_q), .out_fire(out_fire),
		.sts(sts), .out_word(out_word), .out_nb(out_nb), .out_end(out_end)
	);

	assign m_tdata = {5'd0, out_nb, out_word};
	assign m_tlast = out_end;

endmodule

>>> bench/tb_blake2s_hash_engine.sv
// ----------------------------------------------------------------------------
// BLAKE2s hash engine testbench
// Streams plain and keyed messages of varied length and digest size into the
// engine and compares every digest beat with an in-bench BLAKE2s predictor.
// ----------------------------------------------------------------------------
module tb_blake2s_hash_engine;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	localparam logic [31:0] IV_W [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372,
		32'hA54FF53A, 32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	localparam logic [3:0] PERM [10][16] = '{
		'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 13, 12, 0}};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        done;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // message_word[31:0], valid_bytes[34:32], zero pad
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // digest_word[31:0], digest_valid_bytes[34:32], zero pad
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// Predictor copy of configuration and hash state.
	logic [5:0]  cfg_digest_len;
	logic [5:0]  cfg_key_len;
	logic [63:0] cfg_key [4];
	logic [31:0] chain [8];
	logic [63:0] total_bytes;
	logic [31:0] blk [16];
	int          fill;
	bit          msg_open;

	digest_beat_t digest_q[$];
	int          fail_count;
	int          beat_count;
	int          msg_count;
	int          idle_cycles;

	blake2s_hash_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] keep_bytes(input int n);
		return n >= 4 ? 32'hFFFF_FFFF : (32'h1 << (8 * n)) - 32'h1;
	endfunction

	function automatic int digest_bytes();
		if (cfg_digest_len == 6'd0)
			return 1;
		if (cfg_digest_len > 6'd32)
			return 32;
		return int'(cfg_digest_len);
	endfunction

	// One BLAKE2s compression of the block store into the chain value.
	task automatic compress_block(input bit final_blk);
		logic [31:0] v [16];
		int a [8], b [8], c [8], d [8];
		a = '{0, 1, 2, 3, 0, 1, 2, 3};
		b = '{4, 5, 6, 7, 5, 6, 7, 4};
		c = '{8, 9, 10, 11, 10, 11, 8, 9};
		d = '{12, 13, 14, 15, 15, 12, 13, 14};
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[i + 8] = IV_W[i];
		end
		v[12] ^= total_bytes[31:0];
		v[13] ^= total_bytes[63:32];
		if (final_blk)
			v[14] = ~v[14];
		for (int r = 0; r < 10; r++) begin
			for (int g = 0; g < 8; g++) begin
				v[a[g]] = v[a[g]] + v[b[g]] + blk[PERM[r][2 * g]];
				v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 16);
				v[c[g]] = v[c[g]] + v[d[g]];
				v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 12);
				v[a[g]] = v[a[g]] + v[b[g]] + blk[PERM[r][2 * g + 1]];
				v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 8);
				v[c[g]] = v[c[g]] + v[d[g]];
				v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 7);
			end
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= v[i] ^ v[i + 8];
	endtask

	// Advance the predictor by one accepted message word.
	task automatic hash_word(input logic [31:0] word, input logic [2:0] vb,
		input bit last);
		int nb;
		int kl;
		int olen;
		int nwords;
		digest_beat_t beat;
		nb = last ? (vb > 3'd4 ? 4 : int'(vb)) : 4;
		if (!msg_open) begin
			kl = cfg_key_len > 6'd32 ? 32 : int'(cfg_key_len);
			chain = IV_W;
			chain[0] ^= b2s_pkg::PARAM_BASE ^ (32'(kl) << 8) ^ 32'(digest_bytes());
			total_bytes = '0;
			fill = 0;
			if (kl > 0) begin
				for (int i = 0; i < 16; i++) begin
					blk[i] = '0;
					if (i < 8 && 4 * i < kl)
						blk[i] = cfg_key[i / 2][32 * (i % 2) +: 32] & keep_bytes(kl - 4 * i);
				end
				fill = 64;
			end
			msg_open = 1'b1;
		end
		if (nb > 0) begin
			if (fill >= 64) begin
				total_bytes += 64;
				compress_block(1'b0);
				fill = 0;
			end
			blk[fill / 4] = word & keep_bytes(nb);
			fill += nb;
		end
		if (!last)
			return;
		total_bytes += 64'(fill);
		for (int i = (fill + 3) / 4; i < 16; i++)
			blk[i] = '0;
		compress_block(1'b1);
		fill = 0;
		msg_open = 1'b0;
		olen = digest_bytes();
		nwords = (olen + 3) / 4;
		for (int k = 0; k < nwords; k++) begin
			beat.nbytes = 3'((olen - 4 * k) > 4 ? 4 : olen - 4 * k);
			beat.word = chain[k] & keep_bytes(int'(beat.nbytes));
			beat.done = (k + 1 == nwords);
			digest_q.push_back(beat);
		end
	endtask

	// Write one configuration register; only called while the engine is idle.
	task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (index)
			b2s_pkg::REG_DIGEST_LEN: cfg_digest_len = value[5:0];
			b2s_pkg::REG_KEY_LEN: cfg_key_len = value[5:0];
			b2s_pkg::REG_KEY0: cfg_key[0] = value;
			b2s_pkg::REG_KEY1: cfg_key[1] = value;
			b2s_pkg::REG_KEY2: cfg_key[2] = value;
			b2s_pkg::REG_KEY3: cfg_key[3] = value;
			default: ;
		endcase
	endtask

	// Send one message word after a random gap; valid stays up until the
	// next gap or until the sender drains.
	task automatic send_word(input logic [31:0] word, input logic [2:0] vb, input bit last);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, vb, word};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		hash_word(word, vb, last);
	endtask

	task automatic send_message(input int nwords, input logic [2:0] last_vb);
		for (int i = 0; i < nwords - 1; i++)
			send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom, last_vb, 1'b1);
		msg_count++;
	endtask

	// Wait for all digest beats, then let the engine settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_key(input int kl);
		write_reg(b2s_pkg::REG_KEY_LEN, 64'(kl));
		for (int i = 0; i < 4; i++)
			write_reg(3'(b2s_pkg::REG_KEY0 + i), {$urandom, $urandom});
	endtask

	// Unkeyed messages with edge lengths and every last-word byte count.
	task automatic test_unkeyed_lengths();
		send_message(1, 3'd0);
		for (int vb = 0; vb < 8; vb++)
			send_message(1 + vb, 3'(vb));
		send_message(16, 3'd4);
		send_message(17, 3'd1);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_word(32'h0000_0000, 3'd4, 1'b1);
		msg_count++;
		wait_drained();
	endtask

	// Digest length extremes, including out-of-range values.
	task automatic test_digest_lengths();
		int lens [6];
		lens = '{0, 1, 5, 31, 32, 63};
		foreach (lens[i]) begin
			write_reg(b2s_pkg::REG_DIGEST_LEN, 64'(lens[i]));
			send_message(2, 3'd3);
			wait_drained();
		end
	endtask

	// Keyed hashing, including empty keyed messages and oversized key lengths.
	task automatic test_keyed();
		int klens [5];
		klens = '{1, 7, 32, 63, 20};
		foreach (klens[i]) begin
			set_key(klens[i]);
			write_reg(b2s_pkg::REG_DIGEST_LEN, 64'($urandom_range(1, 32)));
			send_message(1, 3'd0);
			send_message($urandom_range(1, 20), 3'($urandom_range(0, 4)));
			wait_drained();
		end
		write_reg(b2s_pkg::REG_KEY_LEN, 64'd0);
		write_reg(b2s_pkg::REG_DIGEST_LEN, 64'd32);
		wait_drained();
	endtask

	// Random messages, mostly short, with random settings between batches.
	task automatic test_random_messages();
		int sent;
		int n;
		sent = 0;
		while (sent < 210) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(b2s_pkg::REG_DIGEST_LEN, 64'($urandom_range(0, 63)));
				set_key($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 40));
			end
			for (int m = 0; m < 4; m++) begin
				n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 40) : $urandom_range(1, 8);
				send_message(n, 3'($urandom_range(0, 7)));
				sent += n;
			end
			// Hold the sender until the engine has answered everything.
			wait_drained();
		end
	endtask

	// Random backpressure on the digest side.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (idle_cycles > 0) begin
			m_tready <= 1'b0;
			idle_cycles <= idle_cycles - 1;
		end else if (m_tvalid && m_tready) begin
			if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				idle_cycles <= $urandom_range(0, 6);
			end
		end else
			m_tready <= 1'b1;
	end

	// Compare each digest beat with the oldest prediction.
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n && m_tvalid && m_tready) begin
			beat_count++;
			if (digest_q.size() == 0) begin
				$error("unexpected digest beat %h", m_tdata);
				fail_count++;
			end else begin
				exp_beat = digest_q.pop_front();
				if (m_tdata[31:0] !== exp_beat.word) begin
					$error("digest_word exp %h got %h", exp_beat.word, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[34:32] !== exp_beat.nbytes) begin
					$error("digest_valid_bytes exp %0d got %0d", exp_beat.nbytes,
						m_tdata[34:32]);
					fail_count++;
				end
				if (m_tlast !== exp_beat.done) begin
					$error("digest_done exp %0d got %0d", exp_beat.done, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		fail_count = 0;
		beat_count = 0;
		msg_count = 0;
		msg_open = 1'b0;
		cfg_digest_len = 6'd32;
		cfg_key_len = 6'd0;
		cfg_key = '{default: '0};
		fill = 0;
		total_bytes = '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unkeyed_lengths();
		test_digest_lengths();
		test_keyed();
		test_random_messages();
		wait_drained();
		$display("Hashed %0d messages, checked %0d digest beats.", msg_count, beat_count);
		$display("Covered keyed and unkeyed modes, digest lengths 0 to 63, backpressure.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/b2s_pkg.sv
rtl/b2s_ctrl.sv
rtl/b2s_datapath.sv
rtl/blake2s_hash_engine.sv
bench/tb_blake2s_hash_engine.sv
